// ----- sv/ota_pkg.sv -----
// shared types, codes and constants for the image sender controller
`timescale 1ns / 1ps
package ota_pkg;

  localparam int unsigned MaxImageBytes = 262144;
  localparam int unsigned PayloadBytes  = 512;
  localparam int unsigned PayloadShift  = $clog2(PayloadBytes);

  localparam int unsigned LenW  = 19;
  localparam int unsigned PktW  = 10;
  localparam int unsigned TimeW = 11;
  localparam int unsigned DvdW  = 16;

  // input operation codes
  localparam logic [2:0] OpStart  = 3'd0;
  localparam logic [2:0] OpTick   = 3'd1;
  localparam logic [2:0] OpTxDone = 3'd2;
  localparam logic [2:0] OpRxDone = 3'd3;

  // radio command codes
  localparam logic [2:0] CmdNone     = 3'd0;
  localparam logic [2:0] CmdHsReq    = 3'd1;
  localparam logic [2:0] CmdListen   = 3'd2;
  localparam logic [2:0] CmdHsAck    = 3'd3;
  localparam logic [2:0] CmdInitSend = 3'd4;
  localparam logic [2:0] CmdSend     = 3'd5;
  localparam logic [2:0] CmdClose    = 3'd6;

  // status codes
  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StHs      = 3'd1;
  localparam logic [2:0] StUpgrade = 3'd2;
  localparam logic [2:0] StDone    = 3'd3;
  localparam logic [2:0] StFailed  = 3'd4;
  localparam logic [2:0] StSame    = 3'd5;

  // burn reply codes
  localparam logic [7:0] BurnResend = 8'd2;
  localparam logic [7:0] BurnFinish = 8'd3;

  // timeouts in ms
  localparam logic [TimeW-1:0] HsTxTime  = 11'd50;
  localparam logic [TimeW-1:0] HsRspBase = 11'd35;
  localparam logic [TimeW-1:0] AckTime   = 11'd1000;
  localparam logic [TimeW-1:0] PktTime   = 11'd2000;

  localparam logic [4:0] HsRspLen = 5'd8;
  localparam logic [4:0] BurnLen  = 5'd3;
  localparam logic [6:0] FullPct  = 7'd100;

  typedef enum logic [9:0] {
    PH_IDLE    = 10'b0000000001,
    PH_HS_TX   = 10'b0000000010,
    PH_HS_RSP  = 10'b0000000100,
    PH_ACK_TX  = 10'b0000001000,
    PH_BCN     = 10'b0000010000,
    PH_SENDING = 10'b0000100000,
    PH_FINISH  = 10'b0001000000,
    PH_DONE    = 10'b0010000000,
    PH_FAILED  = 10'b0100000000,
    PH_SAME    = 10'b1000000000
  } phase_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [3:0]  slot_number;
    logic        is_data_slot;
    logic [4:0]  rx_length;
    logic [31:0] rx_low_word;
    logic [31:0] rx_high_word;
    logic        radio_ok;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        first_init;
    logic [9:0]  packet_index;
    logic [9:0]  packet_length;
    logic [31:0] terminal_low_word;
    logic [31:0] terminal_high_word;
    logic [2:0]  status;
    logic [6:0]  progress;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic step;
    logic prep;
    logic div;
    logic load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_free;
  } ctl_sts_t;

endpackage

// ----- sv/ota_datapath.sv -----
// protocol state, step logic, percent divider and output register
`timescale 1ns / 1ps
module ota_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [18:0]       cfg_data,
  input  ota_pkg::in_item_t in_item,
  input  ota_pkg::ctl_cmd_t ctl,
  output ota_pkg::ctl_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output ota_pkg::out_item_t out_item
);

  localparam int unsigned LenW = ota_pkg::LenW;
  localparam int unsigned PktW = ota_pkg::PktW;
  localparam int unsigned TimeW = ota_pkg::TimeW;
  localparam int unsigned DvdW = ota_pkg::DvdW;

  logic [LenW-1:0]  image_length;
  ota_pkg::phase_t  phase, phase_next;
  logic [PktW-1:0]  next_packet, next_packet_next;
  logic [PktW-1:0]  packet_total, packet_total_next;
  logic [TimeW-1:0] time_left, time_left_next;
  logic [7:0]       attempt_count, attempt_count_next;
  logic             slot_initialized, slot_initialized_next;
  logic             first_queued, first_queued_next;
  logic [63:0]      receiver_id, receiver_id_next;

  logic [2:0]      cmd_next, cmd_r;
  logic            init_next, init_r;
  logic [PktW-1:0] idx_next, idx_r, len_next, len_r;

  // packet check: {ok, length}
  function automatic logic [PktW:0] pkt_check(input logic [15:0] idx,
                                              input logic [PktW-1:0] total,
                                              input logic [LenW-1:0] ilen);
    logic [LenW:0] off;
    logic [LenW:0] rem;
    logic          hit;
    logic [PktW-1:0] plen;
    off  = (LenW+1)'(idx[PktW-1:0] - 1'b1) << ota_pkg::PayloadShift;
    hit  = (idx != 16'd0) && (idx <= {6'd0, total}) && (off < {1'b0, ilen});
    rem  = {1'b0, ilen} - off;
    plen = (rem > (LenW+1)'(ota_pkg::PayloadBytes)) ? PktW'(ota_pkg::PayloadBytes)
                                                     : rem[PktW-1:0];
    return {hit, plen};
  endfunction

  // one protocol step for the accepted beat
  always_comb begin
    logic [PktW:0]   chk;
    logic [LenW:0]   tot_sum;
    logic            active;
    logic            ok;
    logic [TimeW-1:0] tl_dec;
    logic [7:0]      code;
    chk = '0;
    tot_sum = '0;
    ok = in_item.radio_ok;
    code = in_item.rx_low_word[23:16];
    active = !(phase == ota_pkg::PH_IDLE || phase == ota_pkg::PH_DONE ||
               phase == ota_pkg::PH_FAILED || phase == ota_pkg::PH_SAME);
    tl_dec = (time_left != '0) ? time_left - 1'b1 : time_left;
    phase_next = phase;
    next_packet_next = next_packet;
    packet_total_next = packet_total;
    time_left_next = time_left;
    attempt_count_next = attempt_count;
    slot_initialized_next = slot_initialized;
    first_queued_next = first_queued;
    receiver_id_next = receiver_id;
    cmd_next = ota_pkg::CmdNone;
    init_next = 1'b0;
    idx_next = '0;
    len_next = '0;
    if (in_item.op == ota_pkg::OpStart) begin
      if (!active) begin
        if (image_length == '0 ||
            {1'b0, image_length} > (LenW+1)'(ota_pkg::MaxImageBytes)) begin
          phase_next = ota_pkg::PH_FAILED;
        end else begin
          tot_sum = {1'b0, image_length} + (LenW+1)'(ota_pkg::PayloadBytes - 1);
          packet_total_next = PktW'(tot_sum >> ota_pkg::PayloadShift);
          cmd_next = ota_pkg::CmdHsReq;
          init_next = 1'b1;
          if (ok) begin
            slot_initialized_next = 1'b1;
            attempt_count_next = 8'd1;
            time_left_next = ota_pkg::HsTxTime;
            phase_next = ota_pkg::PH_HS_TX;
          end else begin
            attempt_count_next = 8'd0;
            cmd_next = ota_pkg::CmdClose;
            slot_initialized_next = 1'b0;
            phase_next = ota_pkg::PH_FAILED;
          end
        end
      end
    end else if (active) begin
      case (in_item.op)
        ota_pkg::OpTick: begin
          time_left_next = tl_dec;
          if (tl_dec == '0) begin
            if (phase == ota_pkg::PH_HS_TX || phase == ota_pkg::PH_HS_RSP) begin
              cmd_next = ota_pkg::CmdHsReq;
              init_next = !slot_initialized;
              if (ok) begin
                slot_initialized_next = 1'b1;
                attempt_count_next = attempt_count + 8'd1;
                time_left_next = ota_pkg::HsTxTime;
                phase_next = ota_pkg::PH_HS_TX;
              end
            end else begin
              cmd_next = ota_pkg::CmdClose;
              slot_initialized_next = 1'b0;
              phase_next = ota_pkg::PH_FAILED;
            end
          end
        end
        ota_pkg::OpTxDone: begin
          if (phase == ota_pkg::PH_HS_TX) begin
            cmd_next = ota_pkg::CmdListen;
            if (ok) begin
              time_left_next = ota_pkg::HsRspBase +
                               TimeW'({attempt_count[1:0], 2'b00} + attempt_count[1:0]);
              phase_next = ota_pkg::PH_HS_RSP;
            end else begin
              cmd_next = ota_pkg::CmdClose;
              slot_initialized_next = 1'b0;
              phase_next = ota_pkg::PH_FAILED;
            end
          end else if (phase == ota_pkg::PH_ACK_TX) begin
            chk = pkt_check(16'd1, packet_total, image_length);
            next_packet_next = PktW'(1);
            slot_initialized_next = 1'b0;
            if (chk[PktW] && ok) begin
              cmd_next = ota_pkg::CmdInitSend;
              idx_next = PktW'(1);
              len_next = chk[PktW-1:0];
              next_packet_next = PktW'(2);
              first_queued_next = 1'b1;
              phase_next = ota_pkg::PH_BCN;
              time_left_next = ota_pkg::PktTime;
            end else begin
              first_queued_next = 1'b0;
              cmd_next = ota_pkg::CmdClose;
              phase_next = ota_pkg::PH_FAILED;
            end
          end else if (phase == ota_pkg::PH_SENDING && in_item.slot_number == 4'd1) begin
            chk = pkt_check({6'd0, next_packet}, packet_total, image_length);
            if (next_packet > packet_total) begin
              phase_next = ota_pkg::PH_FINISH;
              time_left_next = ota_pkg::PktTime;
            end else if (chk[PktW] && ok) begin
              cmd_next = ota_pkg::CmdSend;
              idx_next = next_packet;
              len_next = chk[PktW-1:0];
              time_left_next = ota_pkg::PktTime;
              next_packet_next = next_packet + 1'b1;
              phase_next = (next_packet_next > packet_total) ? ota_pkg::PH_FINISH
                                                             : ota_pkg::PH_SENDING;
            end else begin
              cmd_next = ota_pkg::CmdClose;
              slot_initialized_next = 1'b0;
              phase_next = ota_pkg::PH_FAILED;
            end
          end
        end
        ota_pkg::OpRxDone: begin
          if (phase == ota_pkg::PH_HS_RSP) begin
            if (in_item.rx_length == ota_pkg::HsRspLen) begin
              if (&in_item.rx_low_word && &in_item.rx_high_word) begin
                cmd_next = ota_pkg::CmdClose;
                slot_initialized_next = 1'b0;
                phase_next = ota_pkg::PH_SAME;
              end else begin
                receiver_id_next = {in_item.rx_high_word, in_item.rx_low_word};
                cmd_next = ota_pkg::CmdHsAck;
                if (ok) begin
                  time_left_next = ota_pkg::AckTime;
                  phase_next = ota_pkg::PH_ACK_TX;
                end else begin
                  cmd_next = ota_pkg::CmdClose;
                  slot_initialized_next = 1'b0;
                  phase_next = ota_pkg::PH_FAILED;
                end
              end
            end
          end else if ((phase == ota_pkg::PH_BCN || phase == ota_pkg::PH_SENDING) &&
                       !in_item.is_data_slot && in_item.slot_number == 4'd0) begin
            if (phase == ota_pkg::PH_BCN && first_queued) begin
              phase_next = ota_pkg::PH_SENDING;
            end
          end else if (((phase == ota_pkg::PH_BCN || phase == ota_pkg::PH_SENDING) ||
                        (phase == ota_pkg::PH_FINISH && in_item.is_data_slot)) &&
                       in_item.rx_length == ota_pkg::BurnLen) begin
            // burn reply: resend request or finish
            if (code == ota_pkg::BurnResend) begin
              chk = pkt_check(in_item.rx_low_word[15:0], packet_total, image_length);
              if (chk[PktW] && ok) begin
                cmd_next = ota_pkg::CmdSend;
                idx_next = in_item.rx_low_word[PktW-1:0];
                len_next = chk[PktW-1:0];
                time_left_next = ota_pkg::PktTime;
                phase_next = (next_packet > packet_total) ? ota_pkg::PH_FINISH
                                                          : ota_pkg::PH_SENDING;
              end else begin
                cmd_next = ota_pkg::CmdClose;
                slot_initialized_next = 1'b0;
                phase_next = ota_pkg::PH_FAILED;
              end
            end else if (code == ota_pkg::BurnFinish) begin
              cmd_next = ota_pkg::CmdClose;
              slot_initialized_next = 1'b0;
              phase_next = ota_pkg::PH_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // config register and protocol state
  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= '0;
      phase <= ota_pkg::PH_IDLE;
      next_packet <= '0;
      packet_total <= '0;
      time_left <= '0;
      attempt_count <= '0;
      slot_initialized <= 1'b0;
      first_queued <= 1'b0;
      receiver_id <= '0;
    end else begin
      if (cfg_we) begin
        image_length <= cfg_data;
      end
      if (ctl.step) begin
        phase <= phase_next;
        next_packet <= next_packet_next;
        packet_total <= packet_total_next;
        time_left <= time_left_next;
        attempt_count <= attempt_count_next;
        slot_initialized <= slot_initialized_next;
        first_queued <= first_queued_next;
        receiver_id <= receiver_id_next;
      end
    end
  end

  // per-beat command fields
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      cmd_r <= cmd_next;
      init_r <= init_next;
      idx_r <= idx_next;
      len_r <= len_next;
    end
  end

  // progress percent: restoring divider, one quotient bit per cycle
  logic [DvdW-1:0] dvd;
  logic [PktW-1:0] rem;
  logic [6:0]      quo;
  logic [3:0]      div_cnt;
  logic            prog_fix;
  logic [6:0]      prog_val;
  logic [2:0]      status_r;
  logic [PktW:0]   rem_sh;
  logic            rem_ge;
  logic [PktW-1:0] sent;
  logic            upgrading;

  assign rem_sh = {rem, dvd[DvdW-1]};
  assign rem_ge = rem_sh >= {1'b0, packet_total};
  assign sent = (next_packet == '0) ? '0 :
                ((next_packet - 1'b1) > packet_total) ? packet_total : next_packet - 1'b1;
  assign upgrading = phase == ota_pkg::PH_BCN || phase == ota_pkg::PH_SENDING ||
                     phase == ota_pkg::PH_FINISH;

  always_ff @(posedge clk) begin
    if (ctl.prep) begin
      dvd <= DvdW'(sent * 7'd100);
      rem <= '0;
      quo <= '0;
      div_cnt <= '0;
      prog_fix <= !upgrading || packet_total == '0;
      prog_val <= (phase == ota_pkg::PH_DONE || phase == ota_pkg::PH_SAME) ?
                  ota_pkg::FullPct : 7'd0;
      case (phase)
        ota_pkg::PH_IDLE:   status_r <= ota_pkg::StIdle;
        ota_pkg::PH_DONE:   status_r <= ota_pkg::StDone;
        ota_pkg::PH_FAILED: status_r <= ota_pkg::StFailed;
        ota_pkg::PH_SAME:   status_r <= ota_pkg::StSame;
        default:            status_r <= upgrading ? ota_pkg::StUpgrade : ota_pkg::StHs;
      endcase
    end else if (ctl.div) begin
      dvd <= {dvd[DvdW-2:0], 1'b0};
      rem <= rem_ge ? PktW'(rem_sh - {1'b0, packet_total}) : rem_sh[PktW-1:0];
      quo <= {quo[5:0], rem_ge};
      div_cnt <= div_cnt + 4'd1;
    end
  end

  assign sts.div_last = div_cnt == 4'd15;
  assign sts.out_free = !out_valid || out_ready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_item.command <= cmd_r;
      out_item.first_init <= init_r;
      out_item.packet_index <= idx_r;
      out_item.packet_length <= len_r;
      out_item.terminal_low_word <= receiver_id[31:0];
      out_item.terminal_high_word <= receiver_id[63:32];
      out_item.status <= status_r;
      out_item.progress <= prog_fix ? prog_val : quo;
    end
  end

endmodule

// ----- sv/ota_ctrl.sv -----
// sequencer: accept, step, divide, hand result to the output register
`timescale 1ns / 1ps
module ota_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ota_pkg::ctl_sts_t sts,
  output ota_pkg::ctl_cmd_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_LOAD = 4'b1000
  } ctl_state_t;

  ctl_state_t state, state_next;

  assign in_ready = state == S_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.step = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        ctl.prep = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div = 1'b1;
        if (sts.div_last) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts.out_free) begin
          ctl.load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/ota_image_sender_fsm.sv -----
// Firmware image sender controller, top level.
//
// Channels: in (valid/ready, one event beat: start, 1 ms tick or radio event),
// out (valid/ready, one result beat per input beat), cfg (valid/ready, writes
// image_length; always ready, take it only while the block is idle).
// Each input beat is stepped through the protocol state at acceptance, then
// the progress percent is formed by a restoring divider, and the result
// enters the output register. No new input beat is taken until the result
// of the last one has entered the output register.
// The output register lets a new beat be accepted while a result waits; if
// the receiver stalls, the following result waits in the sequencer and no
// further beat is taken until the output register frees.
// Reset (synchronous) returns to idle with all protocol state and
// image_length cleared and no result pending.
`timescale 1ns / 1ps
module ota_image_sender_fsm (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ota_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output ota_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [18:0]        cfg_data
);

  ota_pkg::ctl_cmd_t ctl;
  ota_pkg::ctl_sts_t sts;

  assign cfg_ready = 1'b1;

  ota_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ota_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .ctl       (ctl),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- sv/ota_checker.sv -----
// port-level checks for the image sender, bound to the top level
`timescale 1ns / 1ps
module ota_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input ota_pkg::out_item_t out_item
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result beat changed while stalled");

  // packet fields only with a send command
  a_pkt_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.command != ota_pkg::CmdSend &&
    out_item.command != ota_pkg::CmdInitSend |->
    out_item.packet_index == '0 && out_item.packet_length == '0)
    else $error("packet fields set without send command");

  // first_init only with a handshake request or a close command
  a_init: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.first_init |->
    out_item.command == ota_pkg::CmdHsReq || out_item.command == ota_pkg::CmdClose)
    else $error("first_init with wrong command");

  // progress is full when finished and never above full
  a_prog: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.progress <= ota_pkg::FullPct &&
    ((out_item.status != ota_pkg::StDone && out_item.status != ota_pkg::StSame) ||
     out_item.progress == ota_pkg::FullPct))
    else $error("bad progress value");

endmodule

bind ota_image_sender_fsm ota_checker u_ota_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// ----- sim/tb_ota_image_sender_fsm.sv -----
// testbench for the image sender controller: directed and random protocol sessions checked beat by beat
`timescale 1ns / 1ps
module tb_ota_image_sender_fsm;

  // sender model phases
  typedef enum logic [3:0] {
    S_IDLE, S_HS_TX, S_HS_RSP, S_ACK_TX, S_BCN, S_SENDING, S_FINISH, S_DONE, S_FAILED, S_SAME
  } sender_phase_t;

  // expected result store and checker
  class result_board;
    ota_pkg::out_item_t pending[$];
    int errors;
    int matched;
    sender_phase_t ph;
    logic [9:0] next_pkt, pkt_total;
    logic [10:0] time_left;
    logic [7:0] attempts;
    bit slot_init, first_queued;
    logic [63:0] rx_id;
    logic [18:0] img_len;
    ota_pkg::out_item_t r;

    function void clear();
      ph = S_IDLE; next_pkt = '0; pkt_total = '0; time_left = '0; attempts = '0;
      slot_init = 1'b0; first_queued = 1'b0; rx_id = '0; img_len = '0;
      pending.delete(); errors = 0; matched = 0;
    endfunction

    function bit busy();
      return !(ph inside {S_IDLE, S_DONE, S_FAILED, S_SAME});
    endfunction

    function void fail_close();
      r.command = ota_pkg::CmdClose; slot_init = 1'b0; ph = S_FAILED;
    endfunction

    function bit hs_request(bit ok);
      r.command = ota_pkg::CmdHsReq;
      r.first_init = !slot_init;
      if (!ok) return 0;
      slot_init = 1'b1; attempts = attempts + 8'd1; time_left = ota_pkg::HsTxTime;
      ph = S_HS_TX;
      return 1;
    endfunction

    function bit send_packet(int unsigned idx, bit ok);
      longint unsigned off, rem;
      if (idx == 0 || idx > pkt_total) return 0;
      off = longint'(idx - 1) * ota_pkg::PayloadBytes;
      rem = (off < img_len) ? img_len - off : 0;
      if (rem == 0 || !ok) return 0;
      r.packet_index = 10'(idx);
      r.packet_length = 10'((rem > ota_pkg::PayloadBytes) ? ota_pkg::PayloadBytes : rem);
      time_left = ota_pkg::PktTime;
      return 1;
    endfunction

    function void after_send();
      ph = (next_pkt > pkt_total) ? S_FINISH : S_SENDING;
    endfunction

    function void burn_reply(logic [4:0] len, logic [31:0] lo, bit ok);
      if (len != ota_pkg::BurnLen) return;
      if (lo[23:16] == ota_pkg::BurnResend) begin
        if (send_packet(32'(lo[15:0]), ok)) begin
          r.command = ota_pkg::CmdSend; after_send();
        end else fail_close();
      end else if (lo[23:16] == ota_pkg::BurnFinish) begin
        r.command = ota_pkg::CmdClose; slot_init = 1'b0; ph = S_DONE;
      end
    endfunction

    // advance the sender state by one event beat and queue its result
    function void note_event(ota_pkg::in_item_t it);
      longint unsigned sent;
      r = '0;
      if (it.op == ota_pkg::OpStart) begin
        if (!busy()) begin
          if (img_len == 0 || img_len > ota_pkg::MaxImageBytes) ph = S_FAILED;
          else begin
            pkt_total = 10'((img_len + ota_pkg::PayloadBytes - 1) / ota_pkg::PayloadBytes);
            attempts = '0; slot_init = 1'b0;
            if (!hs_request(it.radio_ok)) fail_close();
          end
        end
      end else if (busy()) begin
        if (it.op == ota_pkg::OpTick) begin
          if (time_left > 0) time_left--;
          if (time_left == 0) begin
            if (ph == S_HS_TX || ph == S_HS_RSP) void'(hs_request(it.radio_ok));
            else fail_close();
          end
        end else if (it.op == ota_pkg::OpTxDone) begin
          if (ph == S_HS_TX) begin
            r.command = ota_pkg::CmdListen;
            if (it.radio_ok) begin
              time_left = ota_pkg::HsRspBase + 11'(attempts[1:0] * 5); ph = S_HS_RSP;
            end else fail_close();
          end else if (ph == S_ACK_TX) begin
            slot_init = 1'b0; next_pkt = 10'd1;
            if (send_packet(1, it.radio_ok)) begin
              r.command = ota_pkg::CmdInitSend; next_pkt = 10'd2; first_queued = 1'b1;
              ph = S_BCN; time_left = ota_pkg::PktTime;
            end else begin
              first_queued = 1'b0; fail_close();
            end
          end else if (ph == S_SENDING && it.slot_number == 4'd1) begin
            if (next_pkt > pkt_total) begin
              ph = S_FINISH; time_left = ota_pkg::PktTime;
            end else if (send_packet(32'(next_pkt), it.radio_ok)) begin
              r.command = ota_pkg::CmdSend; next_pkt++; after_send();
            end else fail_close();
          end
        end else if (it.op == ota_pkg::OpRxDone) begin
          if (ph == S_HS_RSP) begin
            if (it.rx_length == ota_pkg::HsRspLen) begin
              if (it.rx_low_word == '1 && it.rx_high_word == '1) begin
                r.command = ota_pkg::CmdClose; slot_init = 1'b0; ph = S_SAME;
              end else begin
                rx_id = {it.rx_high_word, it.rx_low_word};
                r.command = ota_pkg::CmdHsAck;
                if (it.radio_ok) begin
                  time_left = ota_pkg::AckTime; ph = S_ACK_TX;
                end else fail_close();
              end
            end
          end else if (ph == S_BCN || ph == S_SENDING) begin
            if (!it.is_data_slot && it.slot_number == 4'd0) begin
              if (ph == S_BCN && first_queued) ph = S_SENDING;
            end else burn_reply(it.rx_length, it.rx_low_word, it.radio_ok);
          end else if (ph == S_FINISH) begin
            if (it.is_data_slot) burn_reply(it.rx_length, it.rx_low_word, it.radio_ok);
          end
        end
      end
      r.terminal_low_word = rx_id[31:0];
      r.terminal_high_word = rx_id[63:32];
      case (ph)
        S_IDLE: r.status = ota_pkg::StIdle;
        S_DONE: r.status = ota_pkg::StDone;
        S_FAILED: r.status = ota_pkg::StFailed;
        S_SAME: r.status = ota_pkg::StSame;
        S_BCN, S_SENDING, S_FINISH: r.status = ota_pkg::StUpgrade;
        default: r.status = ota_pkg::StHs;
      endcase
      if (ph == S_DONE || ph == S_SAME) r.progress = ota_pkg::FullPct;
      else if ((ph == S_BCN || ph == S_SENDING || ph == S_FINISH) && pkt_total != 0) begin
        sent = (next_pkt > 0) ? longint'(next_pkt) - 1 : 0;
        if (sent > pkt_total) sent = pkt_total;
        r.progress = 7'((sent * 100) / pkt_total);
      end
      pending.push_back(r);
    endfunction

    function void check_result(ota_pkg::out_item_t got);
      ota_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      matched++;
      if (got.command !== e.command) begin
        $error("command exp %0d got %0d", e.command, got.command); errors++; end
      if (got.first_init !== e.first_init) begin
        $error("first_init exp %0d got %0d", e.first_init, got.first_init); errors++; end
      if (got.packet_index !== e.packet_index) begin
        $error("packet_index exp %0d got %0d", e.packet_index, got.packet_index); errors++; end
      if (got.packet_length !== e.packet_length) begin
        $error("packet_length exp %0d got %0d", e.packet_length, got.packet_length);
        errors++;
      end
      if (got.terminal_low_word !== e.terminal_low_word) begin
        $error("terminal_low_word exp %h got %h", e.terminal_low_word,
               got.terminal_low_word);
        errors++;
      end
      if (got.terminal_high_word !== e.terminal_high_word) begin
        $error("terminal_high_word exp %h got %h", e.terminal_high_word,
               got.terminal_high_word);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++; end
      if (got.progress !== e.progress) begin
        $error("progress exp %0d got %0d", e.progress, got.progress); errors++; end
    endfunction
  endclass

  localparam int unsigned CycleLimit = 2000000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  ota_pkg::in_item_t in_item;
  ota_pkg::out_item_t out_item;
  logic [18:0] cfg_data;

  result_board board;
  int unsigned cycles;
  int unsigned beats_sent;
  bit hold_off;
  int unsigned gap_left, burst_left;

  ota_image_sender_fsm u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // result beat checking
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_item);
  end

  // receiver stall pattern, with an optional long hold-off
  initial begin
    int unsigned n;
    out_ready = 0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      n = $urandom_range(0, 9);
      out_ready = (n < 3) ? 1'b0 : 1'b1;
      if (n == 9) begin
        out_ready = 1;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else @(negedge clk);
    end
  end

  // one event beat, with sender bursts and gaps
  task automatic send_event(ota_pkg::in_item_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_item = it;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_event(it);
    beats_sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // register write while idle
  task automatic write_length(logic [18:0] len);
    drain();
    cfg_data = len;
    cfg_valid = 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.img_len = len;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic ota_pkg::in_item_t mk(logic [2:0] op, logic [3:0] slot, logic data,
                                           logic [4:0] len, logic [31:0] lo,
                                           logic [31:0] hi, logic ok);
    ota_pkg::in_item_t it;
    it.op = op; it.slot_number = slot; it.is_data_slot = data; it.rx_length = len;
    it.rx_low_word = lo; it.rx_high_word = hi; it.radio_ok = ok;
    return it;
  endfunction

  function automatic logic mostly_ok();
    return $urandom_range(0, 19) != 0;
  endfunction

  // random noise beat
  function automatic ota_pkg::in_item_t noise();
    ota_pkg::in_item_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(ota_pkg::in_item_t)-1:0];
    if ($urandom_range(0, 3) != 0) it.rx_length = 5'($urandom_range(0, 16));
    return it;
  endfunction

  // a mostly well-formed upgrade session with random content
  task automatic session();
    int unsigned steps, pick;
    logic [31:0] lo, hi;
    send_event(mk(ota_pkg::OpStart, 4'($urandom), 1'($urandom), 5'($urandom), $urandom,
                  $urandom, mostly_ok()));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 60))
        send_event(mk(ota_pkg::OpTick, 4'($urandom), 1'($urandom), '0, '0, '0,
                      1'($urandom)));
    send_event(mk(ota_pkg::OpTxDone, 4'($urandom), 1'($urandom), '0, $urandom, $urandom,
                  mostly_ok()));
    lo = $urandom; hi = $urandom;
    if ($urandom_range(0, 9) == 0) begin lo = '1; hi = '1; end
    send_event(mk(ota_pkg::OpRxDone, 4'($urandom), 1'($urandom), ota_pkg::HsRspLen, lo, hi,
                  mostly_ok()));
    send_event(mk(ota_pkg::OpTxDone, 4'($urandom), 1'($urandom), '0, '0, '0, mostly_ok()));
    send_event(mk(ota_pkg::OpRxDone, 4'd0, 1'b0, 5'($urandom), $urandom, $urandom, 1'b1));
    steps = $urandom_range(3, 20);
    for (int i = 0; i < steps; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)
        send_event(mk(ota_pkg::OpTxDone, 4'd1, 1'($urandom), '0, $urandom, $urandom,
                      mostly_ok()));
      else if (pick < 14)
        send_event(mk(ota_pkg::OpRxDone, 4'($urandom), 1'b1, ota_pkg::BurnLen,
                      {8'($urandom), ota_pkg::BurnResend, 16'($urandom_range(0, 12))},
                      $urandom, mostly_ok()));
      else if (pick < 16)
        send_event(mk(ota_pkg::OpTick, 4'($urandom), 1'($urandom), '0, '0, '0,
                      1'($urandom)));
      else if (pick < 18)
        send_event(mk(ota_pkg::OpTxDone, 4'($urandom), 1'($urandom), '0, '0, '0,
                      1'($urandom)));
      else
        send_event(noise());
    end
    send_event(mk(ota_pkg::OpRxDone, 4'($urandom), 1'b1, ota_pkg::BurnLen,
                  {8'($urandom), ota_pkg::BurnFinish, 16'($urandom)}, $urandom, 1'b1));
  endtask

  initial begin
    logic [18:0] lens[$];
    board = new();
    board.clear();
    cycles = 0; beats_sent = 0; hold_off = 0; burst_left = 0;
    in_valid = 0; in_item = '0; cfg_valid = 0; cfg_data = '0;
    rst = 1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: idle tick, starts with zero, one-byte and oversize lengths, double start, bad ops, short session
    send_event(mk(ota_pkg::OpTick, '0, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(ota_pkg::OpStart, '0, 1'b0, '0, '0, '0, 1'b1));
    write_length(19'd1);
    send_event(mk(ota_pkg::OpStart, 4'hF, 1'b1, 5'd31, '1, '1, 1'b0));
    write_length(19'd262145);
    send_event(mk(ota_pkg::OpStart, '0, 1'b0, '0, '0, '0, 1'b1));
    write_length(19'd1300);
    send_event(mk(ota_pkg::OpStart, '0, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(ota_pkg::OpStart, '0, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(3'd7, '0, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(3'd4, '0, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(ota_pkg::OpTxDone, '0, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(ota_pkg::OpRxDone, '0, 1'b0, 5'd7, '0, '0, 1'b1));
    send_event(mk(ota_pkg::OpRxDone, '0, 1'b0, ota_pkg::HsRspLen, 32'h1234_5678,
                  32'h9abc_def0, 1'b1));
    send_event(mk(ota_pkg::OpTxDone, '0, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(ota_pkg::OpRxDone, '0, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(ota_pkg::OpTxDone, 4'd1, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(ota_pkg::OpRxDone, 4'd2, 1'b1, ota_pkg::BurnLen,
                  {8'h00, ota_pkg::BurnResend, 16'd1}, '0, 1'b1));
    send_event(mk(ota_pkg::OpRxDone, 4'd2, 1'b1, ota_pkg::BurnLen, {8'h00, 8'd9, 16'd1},
                  '0, 1'b1));
    send_event(mk(ota_pkg::OpTxDone, 4'd1, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(ota_pkg::OpTxDone, 4'd1, 1'b0, '0, '0, '0, 1'b1));
    send_event(mk(ota_pkg::OpRxDone, 4'd2, 1'b1, ota_pkg::BurnLen,
                  {8'hFF, ota_pkg::BurnResend, 16'd0}, '0, 1'b1));

    // long receiver hold-off while the sender keeps offering
    write_length(19'd262144);
    hold_off = 1;
    for (int i = 0; i < 8; i++) send_event(noise());
    drain();

    // random sessions over several lengths, extremes included
    lens = '{19'd1, 19'd512, 19'd513, 19'd2048, 19'd5000, 19'd262144, 19'd0,
             19'h7FFFF, 19'd3000};
    while (beats_sent < 1350) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1) == 0) write_length(lens[$urandom_range(0, lens.size() - 1)]);
        else write_length(19'($urandom_range(1, 6000)));
      end
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 10)) send_event(noise());
      else session();
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 60))
          send_event(mk(ota_pkg::OpTick, 4'($urandom), 1'($urandom), '0, '0, '0,
                        1'($urandom)));
    end

    drain();
    $display("covered %0d event beats, %0d results checked, over several image lengths",
             beats_sent, board.matched);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- ota_image_sender_fsm.f -----
sv/ota_pkg.sv
sv/ota_datapath.sv
sv/ota_ctrl.sv
sv/ota_image_sender_fsm.sv
sv/ota_checker.sv
sim/tb_ota_image_sender_fsm.sv
